// File: rtl/cit_pkg.sv
// cit_pkg: shared types, constants and the splitmix64 mixing steps
// for constant_intern_table. No dependencies.
`timescale 1ns / 1ps
package cit_pkg;

  localparam int unsigned DefTableSlots  = 1024;
  localparam int unsigned DefPoolEntries = 768;

  localparam logic [63:0] MixMulA = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMulB = 64'h94d049bb133111eb;

  typedef enum logic {
    FUNC_INTERN = 1'b0,
    FUNC_GET    = 1'b1
  } func_e;

  // word handed from front (hashing) to back (table walk)
  typedef struct packed {
    func_e       func;
    logic [63:0] value;
    logic [63:0] hash;
    logic [9:0]  id;
  } job_t;

  typedef struct packed {
    logic [9:0]  id;
    logic [63:0] value;
    logic        was_new;
    logic        table_full;
  } res_t;

  // front hasher steps: three partial products per 64-bit multiply
  typedef enum logic [3:0] {
    FR_IDLE,
    FR_MA0,
    FR_MA1,
    FR_MA2,
    FR_MB0,
    FR_MB1,
    FR_MB2,
    FR_FIN,
    FR_OUT
  } fr_state_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_PROBE,
    BK_CHECK,
    BK_VAL,
    BK_CMP,
    BK_GETRD,
    BK_GETDT,
    BK_OUT
  } bk_state_e;

endpackage

// File: rtl/cit_ram.sv
// cit_ram: generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module cit_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/cit_front.sv
// cit_front: accepts input words and computes the splitmix64 hash with one
// shared 32x32 multiplier over seven steps. Depends on cit_pkg.
`timescale 1ns / 1ps
module cit_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cit_pkg::job_t in_job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cit_pkg::job_t out_job_o
);
  import cit_pkg::*;

  fr_state_e   state_q, state_d;
  job_t        job_q, job_d;
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] mixed;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  assign in_ready_o  = (state_q == FR_IDLE);
  assign out_valid_o = (state_q == FR_OUT);
  assign out_job_o   = job_q;

  // input of the second multiply, taken from the first product
  assign mixed = acc_q ^ (acc_q >> 27);

  // shared multiplier; low 64 bits built from three partial products
  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    x_d     = x_q;
    acc_d   = acc_q;
    mul_a   = x_q[31:0];
    mul_b   = MixMulA[31:0];
    case (state_q)
      FR_IDLE: begin
        if (in_valid_i) begin
          job_d   = in_job_i;
          x_d     = in_job_i.value ^ (in_job_i.value >> 30);
          state_d = FR_MA0;
        end
      end
      FR_MA0: begin
        acc_d   = prod;
        state_d = FR_MA1;
      end
      FR_MA1: begin
        mul_a   = x_q[63:32];
        acc_d   = acc_q + {prod[31:0], 32'd0};
        state_d = FR_MA2;
      end
      FR_MA2: begin
        mul_b   = MixMulA[63:32];
        acc_d   = acc_q + {prod[31:0], 32'd0};
        state_d = FR_MB0;
      end
      FR_MB0: begin
        mul_a   = mixed[31:0];
        mul_b   = MixMulB[31:0];
        x_d     = mixed;
        acc_d   = prod;
        state_d = FR_MB1;
      end
      FR_MB1: begin
        mul_a   = x_q[63:32];
        mul_b   = MixMulB[31:0];
        acc_d   = acc_q + {prod[31:0], 32'd0};
        state_d = FR_MB2;
      end
      FR_MB2: begin
        mul_b   = MixMulB[63:32];
        acc_d   = acc_q + {prod[31:0], 32'd0};
        state_d = FR_FIN;
      end
      FR_FIN: begin
        job_d.hash = acc_q ^ (acc_q >> 31);
        state_d    = FR_OUT;
      end
      default: begin
        if (out_ready_i) state_d = FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    x_q   <= x_d;
    acc_q <= acc_d;
  end
endmodule

// File: rtl/cit_fifo.sv
// cit_fifo: two-entry queue between front and back.
// Depends on cit_pkg.
`timescale 1ns / 1ps
module cit_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cit_pkg::job_t in_job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cit_pkg::job_t out_job_o
);
  import cit_pkg::*;

  job_t       buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_job_o   = buf_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_job_i;
  end
endmodule

// File: rtl/cit_back.sv
// cit_back: linear-probe walk of the slot table, value store access,
// insert and result register. Depends on cit_pkg and cit_ram.
`timescale 1ns / 1ps
module cit_back #(
  parameter int unsigned TableSlots  = cit_pkg::DefTableSlots,
  parameter int unsigned PoolEntries = cit_pkg::DefPoolEntries
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cit_pkg::job_t in_job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cit_pkg::res_t out_res_o
);
  import cit_pkg::*;

  localparam int unsigned SlotW = $clog2(TableSlots);
  localparam int unsigned PoolW = $clog2(PoolEntries);
  localparam int unsigned CntW  = $clog2(PoolEntries + 1);
  localparam int unsigned LoadW = CntW + $clog2(TableSlots * 3 + 1) + 2;
  localparam logic [LoadW-1:0] LoadLim = LoadW'(TableSlots * 3);
  localparam logic [CntW-1:0]  PoolLim = CntW'(PoolEntries);

  bk_state_e state_q, state_d;
  job_t      job_q, job_d;
  res_t      res_q, res_d;
  logic [SlotW-1:0] pos_q, pos_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PoolW-1:0] eid_q, eid_d;

  // slot RAMs and value store; slot entry is {valid, id}
  logic             sh_we, se_we, vs_we;
  logic [63:0]      sh_rd, vs_rd;
  logic [PoolW:0]   se_rd, se_wdata;
  logic [PoolW-1:0] vs_addr;

  cit_ram #(.Width(64), .Depth(TableSlots)) u_hash (
    .clk_i, .we_i(sh_we), .addr_i(pos_q), .wdata_i(job_q.hash), .rdata_o(sh_rd)
  );
  cit_ram #(.Width(PoolW + 1), .Depth(TableSlots)) u_entry (
    .clk_i, .we_i(se_we), .addr_i(pos_q), .wdata_i(se_wdata), .rdata_o(se_rd)
  );
  cit_ram #(.Width(64), .Depth(PoolEntries)) u_store (
    .clk_i, .we_i(vs_we), .addr_i(vs_addr), .wdata_i(job_q.value), .rdata_o(vs_rd)
  );

  assign in_ready_o  = (state_q == BK_IDLE);
  assign out_valid_o = (state_q == BK_OUT);
  assign out_res_o   = res_q;

  logic full;
  assign full = ((LoadW'(cnt_q) << 2) >= LoadLim) || (cnt_q >= PoolLim);

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    res_d     = res_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    eid_d     = eid_q;
    sh_we     = 1'b0;
    se_we     = 1'b0;
    vs_we     = 1'b0;
    se_wdata  = {1'b1, cnt_q[PoolW-1:0]};
    vs_addr   = eid_q;
    case (state_q)
      BK_IDLE: begin
        if (in_valid_i) begin
          job_d = in_job_i;
          res_d = '0;
          pos_d = in_job_i.hash[SlotW-1:0];
          if (in_job_i.func == FUNC_GET) begin
            state_d = ((32'(in_job_i.id) < 32'(cnt_q)) &&
                       (32'(in_job_i.id) < PoolEntries)) ? BK_GETRD : BK_OUT;
            eid_d = PoolW'(in_job_i.id);
          end else begin
            state_d = BK_PROBE;
          end
        end
      end
      // clearing pass over the slot entries after reset
      BK_CLEAR: begin
        se_we    = 1'b1;
        se_wdata = '0;
        pos_d    = pos_q + 1'b1;
        if (pos_q == SlotW'(TableSlots - 1)) state_d = BK_IDLE;
      end
      // RAM read of the slot at pos_q is in flight
      BK_PROBE: begin
        state_d = BK_CHECK;
      end
      BK_CHECK: begin
        if (!se_rd[PoolW]) begin
          // empty slot: insert here or refuse at the load limit or with the pool full
          if (full) begin
            res_d.table_full = 1'b1;
          end else begin
            sh_we      = 1'b1;
            se_we      = 1'b1;
            vs_addr    = cnt_q[PoolW-1:0];
            vs_we      = 1'b1;
            res_d.id   = 10'(cnt_q);
            res_d.was_new = 1'b1;
            cnt_d      = cnt_q + 1'b1;
          end
          state_d = BK_OUT;
        end else if (sh_rd == job_q.hash && CntW'(se_rd[PoolW-1:0]) < cnt_q) begin
          eid_d   = se_rd[PoolW-1:0];
          state_d = BK_VAL;
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = BK_PROBE;
        end
      end
      BK_VAL: begin
        state_d = BK_CMP;
      end
      BK_CMP: begin
        if (vs_rd == job_q.value) begin
          res_d.id = 10'(eid_q);
          state_d  = BK_OUT;
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = BK_PROBE;
        end
      end
      BK_GETRD: begin
        state_d = BK_GETDT;
      end
      BK_GETDT: begin
        res_d.value = vs_rd;
        state_d     = BK_OUT;
      end
      default: begin
        if (out_ready_i) state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    res_q <= res_d;
    eid_q <= eid_d;
  end
endmodule

// File: rtl/constant_intern_table.sv
// constant_intern_table: top level; front hasher, queue, back table walker.
// Depends on cit_pkg, cit_front, cit_fifo, cit_back, cit_ram.
//
//  channel  | direction | tdata (low bit up)                  | tuser
//  s_axis   | in        | value_in[63:0], id_in[73:64]        | func
//  m_axis   | out       | id_out[9:0], value_out[73:10]       | was_new, table_full
//
// Front: takes a new word only when idle, then six 32x32 multiply steps, final
// xor and hand-off; the queue registers each word. Back: an intern walks idle,
// then probe and check per slot probed including the empty one, val and cmp per
// full-hash match checked in the value store, then out; a get walks idle, getrd,
// getdt and out, and a get of an unassigned id walks idle and out.
// After reset the back clears every slot entry first.
// A stalled m_axis holds the back; the queue lets the front keep hashing.
`timescale 1ns / 1ps
module constant_intern_table #(
  parameter int unsigned TableSlots  = cit_pkg::DefTableSlots,
  parameter int unsigned PoolEntries = cit_pkg::DefPoolEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // value_in[63:0], id_in[73:64], zeros
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // id_out[9:0], value_out[73:10], zeros
  output logic [1:0]  m_axis_tuser    // was_new[0], table_full[1]
);
  import cit_pkg::*;

  job_t in_job, f_job, q_job;
  res_t res;
  logic f_valid, f_ready, q_valid, q_ready;

  assign in_job.func  = func_e'(s_axis_tuser);
  assign in_job.value = s_axis_tdata[63:0];
  assign in_job.id    = s_axis_tdata[73:64];
  assign in_job.hash  = '0;

  cit_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_job_i(in_job),
    .out_valid_o(f_valid), .out_ready_i(f_ready), .out_job_o(f_job)
  );

  cit_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_job_i(f_job),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_job_o(q_job)
  );

  cit_back #(.TableSlots(TableSlots), .PoolEntries(PoolEntries)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_job_i(q_job),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res)
  );

  assign m_axis_tdata = {6'd0, res.value, res.id};
  assign m_axis_tuser = {res.table_full, res.was_new};
endmodule

// File: tb/tb_constant_intern_table.sv
// tb_constant_intern_table: self-checking bench for constant_intern_table.
// Drives intern/get words with random bursts and back-pressure, predicts ids and
// values with a local splitmix64 hash table model. Depends on cit_pkg and the RTL.
`timescale 1ns / 1ps
module tb_constant_intern_table;
  import cit_pkg::*;

  localparam int unsigned Slots = DefTableSlots;
  localparam int unsigned Pool  = DefPoolEntries;
  localparam int unsigned MaxCycles = 3000000;

  typedef struct packed {
    func_e       func;
    logic [63:0] value;
    logic [9:0]  id;
  } op_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  constant_intern_table dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // intern table shadow state
  logic [63:0] tbl_hash [Slots];
  logic        tbl_used [Slots];
  logic [9:0]  tbl_id   [Slots];
  logic [63:0] pool_vals [Pool];
  int unsigned pool_count;

  op_t      pending_ops[$];
  res_t     expected_res[$];
  logic [63:0] seen_vals[$];
  int unsigned errors;
  int unsigned cycles;
  bit       hold_rx;   // long receiver hold-off
  bit       hold_tx;   // sender pause until drained
  event     hold_go;

  function automatic logic [63:0] splitmix(input logic [63:0] x);
    x = (x ^ (x >> 30)) * 64'hbf58476d1ce4e5b9;
    x = (x ^ (x >> 27)) * 64'h94d049bb133111eb;
    return x ^ (x >> 31);
  endfunction

  // walk the shadow table and produce the result for one word
  function automatic res_t intern_lookup(input op_t op);
    res_t        r;
    logic [63:0] h;
    int unsigned pos;
    bit          found_empty;
    r = '0;
    found_empty = 1'b0;
    if (op.func == FUNC_GET) begin
      if (op.id < pool_count) r.value = pool_vals[op.id];
      return r;
    end
    h = splitmix(op.value);
    pos = 32'(h % 64'(Slots));
    for (int unsigned n = 0; n < Slots; n++) begin
      if (!tbl_used[pos]) begin
        found_empty = 1'b1;
        break;
      end
      if (tbl_hash[pos] == h && tbl_id[pos] < pool_count &&
          pool_vals[tbl_id[pos]] == op.value) begin
        r.id = tbl_id[pos];
        return r;
      end
      pos = (pos + 1) % Slots;
    end
    if (!found_empty || pool_count * 4 >= Slots * 3 || pool_count >= Pool) begin
      r.table_full = 1'b1;
      return r;
    end
    pool_vals[pool_count] = op.value;
    tbl_hash[pos] = h;
    tbl_id[pos] = 10'(pool_count);
    tbl_used[pos] = 1'b1;
    r.id = 10'(pool_count);
    r.was_new = 1'b1;
    pool_count++;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic op_t rand_op();
    op_t op;
    logic [63:0] v;
    int unsigned k;
    op.func = func_e'($urandom_range(0, 3) == 0);
    k = $urandom_range(0, 9);
    v = {$urandom(), $urandom()};
    // half repeats of earlier values, one in ten a small value 0..15, rest new
    if (k < 5 && seen_vals.size() > 0) v = seen_vals[$urandom_range(0, seen_vals.size() - 1)];
    else if (k == 5) v = 64'($urandom_range(0, 15));
    else seen_vals.push_back(v);
    op.value = v;
    op.id = ($urandom_range(0, 3) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 800));
    return op;
  endfunction

  // driver: bursts with random gaps
  int unsigned burst_left, gap_left;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_res.push_back(intern_lookup(pending_ops.pop_front()));
      end
      if ((s_axis_tvalid && !s_axis_tready) ) begin
        // hold current word
      end else if (hold_tx || pending_ops.size() == 0 ||
                   (s_axis_tvalid && s_axis_tready && pending_ops.size() == 0)) begin
        s_axis_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_ops[0].func;
        s_axis_tdata  <= {6'b0, pending_ops[0].id, pending_ops[0].value};
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(hold_go) begin
    hold_rx = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  // receiver stall pattern plus long hold-off
  int unsigned stall_phase;
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (hold_rx) m_axis_tready <= 1'b0;
    else if (stall_phase[9:8] == 2'b11) m_axis_tready <= 1'b1;
    else m_axis_tready <= (stall_phase[2:0] != 3'd5) && ($urandom_range(0, 4) != 0);
  end

  // monitor
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.id = m_axis_tdata[9:0];
      got.value = m_axis_tdata[73:10];
      got.was_new = m_axis_tuser[0];
      got.table_full = m_axis_tuser[1];
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected word", {54'b0, got.id}, '0);
      end else begin
        want = expected_res.pop_front();
        if (got.id != want.id) report_mismatch("id_out", got.id, want.id);
        if (got.value != want.value) report_mismatch("value_out", got.value, want.value);
        if (got.was_new != want.was_new) report_mismatch("was_new", got.was_new, want.was_new);
        if (got.table_full != want.table_full)
          report_mismatch("table_full", got.table_full, want.table_full);
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycles > MaxCycles) begin
      $display("tb_constant_intern_table: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() != 0 || s_axis_tvalid || expected_res.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] filler;
    for (int i = 0; i < Slots; i++) tbl_used[i] = 1'b0;
    pool_count = 0;
    errors = 0;
    cycles = 0;
    hold_tx = 0;
    burst_left = 0;
    gap_left = 0;
    stall_phase = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: get on empty, extremes, repeats, unassigned ids
    pending_ops.push_back('{FUNC_GET, 64'h0, 10'd0});
    pending_ops.push_back('{FUNC_GET, '1, 10'h3ff});
    pending_ops.push_back('{FUNC_INTERN, 64'h0, 10'h3ff});
    pending_ops.push_back('{FUNC_INTERN, '1, 10'd0});
    pending_ops.push_back('{FUNC_INTERN, 64'h0, 10'd0});
    pending_ops.push_back('{FUNC_INTERN, 64'h8000_0000_0000_0000, 10'd0});
    pending_ops.push_back('{FUNC_INTERN, '1, 10'd0});
    pending_ops.push_back('{FUNC_GET, '1, 10'd0});
    pending_ops.push_back('{FUNC_GET, 64'h0, 10'd1});
    pending_ops.push_back('{FUNC_GET, 64'h0, 10'd2});
    pending_ops.push_back('{FUNC_GET, 64'h0, 10'd3});
    pending_ops.push_back('{FUNC_GET, 64'h0, 10'h3ff});
    pending_ops.push_back('{FUNC_INTERN, 64'h5555_5555_5555_5555, 10'h2aa});
    pending_ops.push_back('{FUNC_INTERN, 64'haaaa_aaaa_aaaa_aaaa, 10'h155});
    pending_ops.push_back('{FUNC_GET, 64'h0, 10'd3});
    pending_ops.push_back('{FUNC_GET, 64'h0, 10'd4});
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    for (int i = 0; i < 60; i++) pending_ops.push_back(rand_op());
    -> hold_go;
    @(posedge clk_i);
    wait (!hold_rx);
    wait_drained();

    // random traffic, with one sender pause until all results are in
    for (int i = 0; i < 800; i++) pending_ops.push_back(rand_op());
    repeat (2000) @(posedge clk_i);
    hold_tx = 1;
    while (s_axis_tvalid || expected_res.size() != 0) @(posedge clk_i);
    hold_tx = 0;
    wait_drained();

    // fill to the load limit
    while (pool_count + 0 < 800 && pending_ops.size() < 700) begin
      filler = {$urandom(), $urandom()};
      seen_vals.push_back(filler);
      pending_ops.push_back('{FUNC_INTERN, filler, 10'd0});
    end
    for (int i = 0; i < 200; i++) pending_ops.push_back(rand_op());
    pending_ops.push_back('{FUNC_GET, 64'h0, 10'd767});
    pending_ops.push_back('{FUNC_GET, 64'h0, 10'd768});
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("tb_constant_intern_table: done, clean");
    else $display("tb_constant_intern_table: done, errors");
    $finish;
  end

endmodule

// File: files.f
rtl/cit_pkg.sv
rtl/cit_ram.sv
rtl/cit_front.sv
rtl/cit_fifo.sv
rtl/cit_back.sv
rtl/constant_intern_table.sv
tb/tb_constant_intern_table.sv
